/* hw/rtl/cmpc_pkg.sv */
`default_nettype none
package cmpc_pkg;

   localparam int MEM_WORDS   = 16384;
   localparam int ADDR_W      = $clog2(MEM_WORDS);
   localparam int WORD_W      = 36;
   localparam int PORT_W      = 2;
   localparam int NUM_PORTS   = 4;
   localparam int LOW_ADDR_W  = 14;
   localparam int SEL_W       = 4;
   localparam int FULL_ADDR_W = SEL_W + LOW_ADDR_W;

   // Bus port indexes used by the connect priority
   localparam logic [PORT_W-1:0] PRIMARY_PORT   = 2'd0;
   localparam logic [PORT_W-1:0] SECONDARY_PORT = 2'd1;
   localparam logic [PORT_W-1:0] SHARED_LO_PORT = 2'd2;
   localparam logic [PORT_W-1:0] SHARED_HI_PORT = 2'd3;

   typedef struct packed {
      logic [PORT_W-1:0]     bus_port;
      logic [NUM_PORTS-1:0]  cycle_requests;
      logic                  read_request;
      logic                  write_request;
      logic [LOW_ADDR_W-1:0] word_address;
      logic [SEL_W-1:0]      module_select;
      logic                  write_restart;
      logic [WORD_W-1:0]     write_data;
   } req_type;

   typedef struct packed {
      logic              no_response;
      logic              address_ack;
      logic              read_restart;
      logic [WORD_W-1:0] read_data;
      logic              data_taken;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic              clearing;
      logic              accept;
      logic              commit;
      logic [ADDR_W-1:0] clear_addr;
   } seq_ctl_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage
`default_nettype wire

/* hw/rtl/cmpc_ram.sv */
`default_nettype none
module cmpc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/cmpc_fsm.sv */
`default_nettype none
module cmpc_fsm (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 out_free,
   output      cmpc_pkg::seq_ctl_type ctl
);
   import cmpc_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic              clear_last;

   assign clear_last = (clear_cnt_ff == {ADDR_W{1'b1}});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctl.clearing   = 1'b0;
      ctl.accept     = 1'b0;
      ctl.commit     = 1'b0;
      ctl.clear_addr = clear_cnt_ff;
      req_stall      = 1'b1;
      case (state_ff)
         ST_CLEAR: ctl.clearing = 1'b1;
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctl.accept = req_valid;
         end
         ST_EXEC:  ctl.commit = out_free;
         default:  ctl.clearing = 1'b0;
      endcase
   end

   assign clear_cnt_in = ctl.clearing ? clear_cnt_ff + 1'b1 : clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      ctl.clearing |-> !ctl.accept)
      else $error("transaction accepted during clearing pass");

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> (state_ff == ST_EXEC) && req_stall)
      else $error("accepted transaction did not enter execution");

   a_stall_unless_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input open outside idle");

endmodule
`default_nettype wire

/* hw/rtl/cmpc_engine.sv */
`default_nettype none
module cmpc_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmpc_pkg::seq_ctl_type ctl,
   input  wire cmpc_pkg::req_type     req_payload,
   input  wire logic [cmpc_pkg::WORD_W-1:0] mem_rdata,
   output      cmpc_pkg::mem_req_type mem_req,
   output      logic                  out_free,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      cmpc_pkg::rsp_type     rsp_payload
);
   import cmpc_pkg::*;

   req_type           item_ff, item_in;
   logic              conn_valid_ff, conn_valid_in;
   logic [PORT_W-1:0] conn_port_ff, conn_port_in;
   logic [PORT_W-1:0] last_shared_ff, last_shared_in;
   logic              awaiting_ff, awaiting_in;
   logic [ADDR_W-1:0] latched_addr_ff, latched_addr_in;
   logic [WORD_W-1:0] word_buf_ff, word_buf_in;
   logic              pause_sync_ff, pause_sync_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [FULL_ADDR_W-1:0] full_req_addr, full_item_addr;
   logic              no_port;
   logic              finish;
   logic              store_wr;
   logic [WORD_W-1:0] store_data;
   rsp_type           result;

   assign full_req_addr  = {req_payload.module_select, req_payload.word_address};
   assign full_item_addr = {item_ff.module_select, item_ff.word_address};

   // Capture the transaction payload as it comes in
   assign item_in = ctl.accept ? req_payload : item_ff;

   always_comb begin
      conn_valid_in   = conn_valid_ff;
      conn_port_in    = conn_port_ff;
      last_shared_in  = last_shared_ff;
      awaiting_in     = awaiting_ff;
      latched_addr_in = latched_addr_ff;
      word_buf_in     = word_buf_ff;
      pause_sync_in   = pause_sync_ff;
      no_port         = 1'b0;
      finish          = 1'b0;
      store_wr        = 1'b0;
      result          = '0;
      result.no_response = 1'b1;

      if (!conn_valid_ff) begin
         if (item_ff.cycle_requests[PRIMARY_PORT]) begin
            conn_port_in = PRIMARY_PORT;
         end else if (item_ff.cycle_requests[SECONDARY_PORT]) begin
            conn_port_in = SECONDARY_PORT;
         end else if (item_ff.cycle_requests[SHARED_LO_PORT] &&
                      item_ff.cycle_requests[SHARED_HI_PORT]) begin
            conn_port_in   = (last_shared_ff == SHARED_LO_PORT) ? SHARED_HI_PORT
                                                                : SHARED_LO_PORT;
            last_shared_in = conn_port_in;
         end else if (item_ff.cycle_requests[SHARED_LO_PORT]) begin
            conn_port_in   = SHARED_LO_PORT;
            last_shared_in = SHARED_LO_PORT;
         end else if (item_ff.cycle_requests[SHARED_HI_PORT]) begin
            conn_port_in   = SHARED_HI_PORT;
            last_shared_in = SHARED_HI_PORT;
         end else begin
            no_port = 1'b1;
         end
         conn_valid_in = !no_port;
      end

      if (!no_port && (item_ff.bus_port == conn_port_in)) begin
         result.no_response = 1'b0;
         if (awaiting_ff && item_ff.cycle_requests[item_ff.bus_port]) begin
            awaiting_in        = 1'b0;
            latched_addr_in    = full_item_addr[ADDR_W-1:0];
            pause_sync_in      = 1'b1;
            word_buf_in        = '0;
            result.address_ack = 1'b1;
            if (item_ff.read_request) begin
               // destructive read: clear the word, restore it at once if no write
               result.read_restart = 1'b1;
               result.read_data    = mem_rdata;
               store_wr            = 1'b1;
               if (!item_ff.write_request) begin
                  word_buf_in   = mem_rdata;
                  conn_valid_in = 1'b0;
               end
            end
            finish = !item_ff.write_request;
         end
         // merge bus data on write restart, stale pause sync included
         if (!finish && pause_sync_in && item_ff.write_restart) begin
            word_buf_in       = word_buf_in | item_ff.write_data;
            result.data_taken = 1'b1;
            finish            = 1'b1;
         end
         if (finish) begin
            conn_valid_in = 1'b0;
            awaiting_in   = 1'b1;
            store_wr      = 1'b1;
         end
      end
      store_data = finish ? word_buf_in : '0;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid_in = ctl.commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_in       = ctl.commit ? result : rsp_ff;

   always_comb begin
      mem_req.rd_en   = ctl.accept;
      mem_req.rd_addr = full_req_addr[ADDR_W-1:0];
      if (ctl.clearing) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = ctl.clear_addr;
         mem_req.wr_data = '0;
      end else begin
         mem_req.wr_en   = ctl.commit && store_wr;
         mem_req.wr_addr = latched_addr_in;
         mem_req.wr_data = store_data;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         conn_valid_ff   <= 1'b0;
         conn_port_ff    <= PRIMARY_PORT;
         last_shared_ff  <= SHARED_LO_PORT;
         awaiting_ff     <= 1'b1;
         latched_addr_ff <= '0;
         word_buf_ff     <= '0;
         pause_sync_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (ctl.commit) begin
            conn_valid_ff   <= conn_valid_in;
            conn_port_ff    <= conn_port_in;
            last_shared_ff  <= last_shared_in;
            awaiting_ff     <= awaiting_in;
            latched_addr_ff <= latched_addr_in;
            word_buf_ff     <= word_buf_in;
            pause_sync_ff   <= pause_sync_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_commit_fills_output: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> rsp_valid_ff)
      else $error("committed transaction produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_no_response_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.no_response) |->
         (!rsp_ff.address_ack && !rsp_ff.read_restart && !rsp_ff.data_taken))
      else $error("unserved transaction reports activity");

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.read_restart) |-> (rsp_ff.read_data == '0))
      else $error("read data present without read restart");

endmodule
`default_nettype wire

/* hw/rtl/core_memory_port_controller.sv */
`default_nettype none
// Accepting a transaction issues the registered read of the core word; then, once the
// output register is free, the execute state commits the write-back and registers the
// result. A new transaction is taken only after the previous one has committed.
// Reset: synchronous, active high; after release the core store is zeroed one word
// per cycle, all MEM_WORDS words (16384 at default), with req_stall held high.
module core_memory_port_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire cmpc_pkg::req_type req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      cmpc_pkg::rsp_type rsp_payload
);
   import cmpc_pkg::*;

   seq_ctl_type       ctl;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rdata;
   logic              out_free;

   // Sequence the clearing pass, then fetch and write-back phases per transaction
   cmpc_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   // Port arbitration, cycle control, restore/merge of the word, result register
   cmpc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_payload (req_payload),
      .mem_rdata   (mem_rdata),
      .mem_req     (mem_req),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Core store: one write and one registered read per cycle
   cmpc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_core_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

endmodule
`default_nettype wire

/* bench/core_memory_port_controller_tb.sv */
`timescale 1ns / 1ps

module core_memory_port_controller_tb;
   import cmpc_pkg::*;

   // Run limit: far above the slowest correct run (store clear after reset,
   // every transaction behind the longest sender gap and receiver stall).
   localparam int LIMIT_CYCLES  = 300_000;
   localparam int RANDOM_EVENTS = 1600;
   localparam int LONG_HOLD     = 300;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   core_memory_port_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // ------------------------------------------------------------------
   // Shadow of the memory module: connection, cycle latches and core words
   // ------------------------------------------------------------------
   logic              m_connected;
   logic [PORT_W-1:0] m_port;
   logic [PORT_W-1:0] m_last_shared;
   logic              m_awaiting;
   logic [ADDR_W-1:0] m_addr;
   logic [WORD_W-1:0] m_buffer;
   logic              m_read;
   logic              m_write;
   logic              m_pause;
   logic [WORD_W-1:0] core_words [MEM_WORDS];

   rsp_type pending_answers [$];

   // Bookkeeping
   int mismatches   = 0;
   int events_sent  = 0;
   int answers_seen = 0;
   int n_ack        = 0;
   int n_read       = 0;
   int n_taken      = 0;
   int n_ignored    = 0;

   // Idle control, shared by the stimulus and the receiver process
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_asks   = 0;

   function automatic void clear_shadow();
      m_connected   = 1'b0;
      m_port        = PRIMARY_PORT;
      m_last_shared = SHARED_LO_PORT;
      m_awaiting    = 1'b1;
      m_addr        = '0;
      m_buffer      = '0;
      m_read        = 1'b0;
      m_write       = 1'b0;
      m_pause       = 1'b0;
      foreach (core_words[i]) core_words[i] = '0;
   endfunction

   // Serve one bus wake event and return what the module answers on the bus.
   function automatic rsp_type serve_event(req_type ev);
      rsp_type ans;
      logic    finish;
      ans             = '0;
      ans.no_response = 1'b1;
      finish          = 1'b0;

      // Connect by priority: port 0, port 1, then the shared pair in turn
      if (!m_connected) begin
         if (ev.cycle_requests[PRIMARY_PORT]) begin
            m_port = PRIMARY_PORT;
         end else if (ev.cycle_requests[SECONDARY_PORT]) begin
            m_port = SECONDARY_PORT;
         end else begin
            if (ev.cycle_requests[SHARED_LO_PORT] && ev.cycle_requests[SHARED_HI_PORT])
               m_port = (m_last_shared == SHARED_LO_PORT) ? SHARED_HI_PORT : SHARED_LO_PORT;
            else if (ev.cycle_requests[SHARED_LO_PORT])
               m_port = SHARED_LO_PORT;
            else if (ev.cycle_requests[SHARED_HI_PORT])
               m_port = SHARED_HI_PORT;
            else
               return ans;
            m_last_shared = m_port;
         end
         m_connected = 1'b1;
      end

      // Events from any other bus are not served
      if (ev.bus_port != m_port)
         return ans;
      ans.no_response = 1'b0;

      // Start a cycle: latch address and requests, acknowledge
      if (m_awaiting && ev.cycle_requests[ev.bus_port]) begin
         m_awaiting      = 1'b0;
         m_buffer        = '0;
         m_read          = ev.read_request;
         m_write         = ev.write_request;
         m_addr          = ADDR_W'({ev.module_select, ev.word_address});
         ans.address_ack = 1'b1;
         if (m_read) begin
            // destructive read
            m_buffer          = core_words[m_addr];
            core_words[m_addr] = '0;
            ans.read_data     = m_buffer;
            ans.read_restart  = 1'b1;
            if (m_write)
               m_buffer = '0;
            else
               m_connected = 1'b0;
         end
         m_pause = 1'b1;
         finish  = !m_write;
      end

      // Write restart merges bus data; pause stays set, so a late one merges too
      if (!finish && m_pause && ev.write_restart) begin
         m_buffer       = m_buffer | ev.write_data;
         ans.data_taken = 1'b1;
         finish         = 1'b1;
      end

      // Restore or store the buffer and release the port
      if (finish) begin
         core_words[m_addr] = m_buffer;
         m_connected        = 1'b0;
         m_awaiting         = 1'b1;
      end
      return ans;
   endfunction

   function automatic logic [NUM_PORTS-1:0] req_line(int p);
      return NUM_PORTS'(1 << p);
   endfunction

   function automatic req_type make_event(logic [PORT_W-1:0] port,
                                          logic [NUM_PORTS-1:0] lines,
                                          logic rd, logic wr,
                                          logic [LOW_ADDR_W-1:0] addr,
                                          logic [SEL_W-1:0] sel,
                                          logic wrs,
                                          logic [WORD_W-1:0] data);
      req_type ev;
      ev.bus_port       = port;
      ev.cycle_requests = lines;
      ev.read_request   = rd;
      ev.write_request  = wr;
      ev.word_address   = addr;
      ev.module_select  = sel;
      ev.write_restart  = wrs;
      ev.write_data     = data;
      return ev;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ALL_ONES;
         default: return WORD_W'({$urandom, $urandom});
      endcase
   endfunction

   // Half the time a small set of words at both ends so reads find earlier writes
   function automatic logic [LOW_ADDR_W-1:0] random_address();
      case ($urandom_range(0, 3))
         0:       return LOW_ADDR_W'($urandom_range(0, 7));
         1:       return LOW_ADDR_W'(MEM_WORDS - 1 - $urandom_range(0, 7));
         default: return LOW_ADDR_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, run limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * LIMIT_CYCLES);
      $display("run limit hit at %0t with %0d results outstanding",
               $time, pending_answers.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------
   // Send one transaction: optional gap, then hold until accepted
   // ------------------------------------------------------------------
   task automatic send_event(input req_type ev);
      rsp_type ans;
      int      gap;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      // drop valid only when a gap follows, so valid never toggles within one step
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      do @(posedge clock); while (req_stall !== 1'b0);

      // accepted at this edge: advance the shadow and queue the answer
      ans = serve_event(ev);
      pending_answers.push_back(ans);
      events_sent++;
      if (ans.address_ack)  n_ack++;
      if (ans.read_restart) n_read++;
      if (ans.data_taken)   n_taken++;
      if (ans.no_response)  n_ignored++;
   endtask

   // A well-formed memory cycle from the connected bus (or any bus when free),
   // followed by fillers and a write restart when the cycle waits for data.
   task automatic send_cycle();
      logic [PORT_W-1:0]    port;
      logic [NUM_PORTS-1:0] lines;
      port  = m_connected ? m_port : PORT_W'($urandom_range(0, NUM_PORTS - 1));
      lines = req_line(port);
      if ($urandom_range(0, 3) == 0)
         lines = lines | NUM_PORTS'($urandom);
      send_event(make_event(port, lines, 1'($urandom), 1'($urandom), random_address(),
                            SEL_W'($urandom), ($urandom_range(0, 4) == 0),
                            random_word()));
      if (!m_awaiting) begin
         repeat ($urandom_range(0, 2))
            send_event(make_event(m_port, NUM_PORTS'($urandom), 1'($urandom),
                                  1'($urandom), LOW_ADDR_W'($urandom), SEL_W'($urandom),
                                  1'b0, random_word()));
         send_event(make_event(m_port, NUM_PORTS'($urandom), 1'($urandom), 1'($urandom),
                               LOW_ADDR_W'($urandom), SEL_W'($urandom), 1'b1,
                               random_word()));
      end
   endtask

   // Anything at all: foreign buses, stale restarts, empty request lines
   task automatic send_noise();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      send_event(raw[$bits(req_type)-1:0]);
   endtask

   // ------------------------------------------------------------------
   // Receiver: per-transaction stall draw, plus a long hold-off on request
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int wait_left;
      int hold_left;
      int hold_seen;
      wait_left = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            wait_left = rsp_idle_on ? $urandom_range(0, 10) : 0;
         else if (wait_left > 0)
            wait_left--;
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (wait_left > 0) || (hold_left > 0);
      end
   end

   task automatic compare_field(input string what, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   // Check every accepted result against the oldest expected answer
   initial begin : answer_check
      rsp_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_payload);
            end else begin
               want = pending_answers.pop_front();
               compare_field("no_response",  WORD_W'(want.no_response),
                             WORD_W'(rsp_payload.no_response));
               compare_field("address_ack",  WORD_W'(want.address_ack),
                             WORD_W'(rsp_payload.address_ack));
               compare_field("read_restart", WORD_W'(want.read_restart),
                             WORD_W'(rsp_payload.read_restart));
               compare_field("read_data",    want.read_data, rsp_payload.read_data);
               compare_field("data_taken",   WORD_W'(want.data_taken),
                             WORD_W'(rsp_payload.data_taken));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // No bus raises a cycle request: stay unconnected, answer no response
   task automatic check_no_request();
      send_event(make_event(PRIMARY_PORT, '0, 1'b1, 1'b1, '0, '0, 1'b1, ALL_ONES));
   endtask

   // Write-only, read with restore, and an empty cycle that clears the word
   task automatic check_write_read_restore();
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b0, 1'b1,
                            '0, '0, 1'b0, '0));
      send_event(make_event(PRIMARY_PORT, '0, 1'b0, 1'b0, '0, '0, 1'b1, ALL_ONES));
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b1, 1'b0,
                            '0, '0, 1'b0, '0));
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b1, 1'b0,
                            '0, '0, 1'b0, '0));
      send_event(make_event(SECONDARY_PORT, req_line(SECONDARY_PORT), 1'b0, 1'b0,
                            '0, '0, 1'b0, ALL_ONES));
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b1, 1'b0,
                            '0, '0, 1'b0, '0));
   endtask

   // Read-modify-write at the top address, restart in the same event and later
   task automatic check_read_write_same_event();
      send_event(make_event(SECONDARY_PORT, req_line(SECONDARY_PORT), 1'b1, 1'b1,
                            '1, '1, 1'b1, 36'h5_A5A5_A5A5));
      send_event(make_event(SECONDARY_PORT, req_line(SECONDARY_PORT), 1'b1, 1'b0,
                            '1, '1, 1'b0, '0));
      send_event(make_event(SECONDARY_PORT, req_line(SECONDARY_PORT), 1'b1, 1'b1,
                            '1, '0, 1'b0, '0));
      send_event(make_event(SECONDARY_PORT, '0, 1'b0, 1'b0, '0, '0, 1'b1, 36'hA_5A5A_5A5A));
   endtask

   // Both shared buses requesting: the one that lost last time wins
   task automatic check_shared_priority();
      logic [NUM_PORTS-1:0] both;
      both = req_line(SHARED_LO_PORT) | req_line(SHARED_HI_PORT);
      send_event(make_event(SHARED_HI_PORT, both, 1'b0, 1'b0, 14'd3, '0, 1'b0, '0));
      send_event(make_event(SHARED_LO_PORT, both, 1'b0, 1'b0, 14'd3, '0, 1'b0, '0));
      send_event(make_event(SHARED_LO_PORT, both, 1'b1, 1'b0, 14'd3, '0, 1'b0, '0));
      send_event(make_event(SHARED_HI_PORT, req_line(SHARED_HI_PORT), 1'b1, 1'b0,
                            14'd3, '0, 1'b0, '0));
   endtask

   // A write restart after the cycle has ended still merges into the last word
   task automatic check_stale_restart();
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b0, 1'b1,
                            14'd5, '0, 1'b0, '0));
      send_event(make_event(PRIMARY_PORT, '0, 1'b0, 1'b0, '0, '0, 1'b1, 36'h1_2345_6789));
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b1, 1'b0,
                            14'd5, '0, 1'b0, '0));
      // connect port 0 through another bus's event, then the late restart
      send_event(make_event(SECONDARY_PORT, req_line(PRIMARY_PORT), 1'b0, 1'b0,
                            '0, '0, 1'b0, '0));
      send_event(make_event(PRIMARY_PORT, '0, 1'b0, 1'b0, '0, '0, 1'b1, 36'h8_0000_0001));
      send_event(make_event(PRIMARY_PORT, req_line(PRIMARY_PORT), 1'b1, 1'b0,
                            14'd5, '0, 1'b0, '0));
   endtask

   // A foreign bus is ignored while another bus holds the module
   task automatic check_foreign_port();
      send_event(make_event(SHARED_LO_PORT, req_line(SHARED_LO_PORT), 1'b0, 1'b1,
                            14'd7, '0, 1'b0, '0));
      send_event(make_event(SECONDARY_PORT, req_line(SECONDARY_PORT), 1'b1, 1'b0,
                            14'd7, '0, 1'b1, ALL_ONES));
      send_event(make_event(SHARED_LO_PORT, '0, 1'b0, 1'b0, '0, '0, 1'b1, 36'h0_F0F0_F0F0));
   endtask

   // Receiver holds off while the sender keeps offering: input must back up
   task automatic check_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_asks <= hold_asks + 1;
      repeat (40) send_cycle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Mostly well-formed cycles with random content, the rest noise;
   // idling is switched off for some stretches
   task automatic check_random_traffic();
      int stop_at;
      int phase_end;
      stop_at   = events_sent + RANDOM_EVENTS;
      phase_end = events_sent;
      while (events_sent < stop_at) begin
         if (events_sent >= phase_end) begin
            phase_end   = events_sent + 150;
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 9) < 7)
            send_cycle();
         else
            send_noise();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      int drain;
      clear_shadow();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      check_no_request();
      check_write_read_restore();
      check_read_write_same_event();
      check_shared_priority();
      check_stale_restart();
      check_foreign_port();
      check_backpressure();
      check_random_traffic();

      req_valid <= 1'b0;
      drain = 0;
      while (pending_answers.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (pending_answers.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, pending_answers.size());

      $display("covered %0d bus events, %0d results: %0d acks, %0d reads, %0d merges, %0d ignored",
               events_sent, answers_seen, n_ack, n_read, n_taken, n_ignored);
      $display("included shared priority, late write restarts, foreign buses, long hold-off");
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/cmpc_pkg.sv
hw/rtl/cmpc_ram.sv
hw/rtl/cmpc_fsm.sv
hw/rtl/cmpc_engine.sv
hw/rtl/core_memory_port_controller.sv
bench/core_memory_port_controller_tb.sv
